// ===== design/bttrk_pkg.sv =====
package bttrk_pkg;

	localparam int MAX_BINS_DEF = 32;
	localparam int BIN_W = 5;
	localparam int CNT_W = 6;
	localparam int XING_W = 12;
	localparam int KEY_W = 7;
	localparam logic [CNT_W-1:0] NUM_BINS_RST = 6'd8;

	localparam logic [1:0] TRACK_BEST = 2'd1;
	localparam logic [1:0] TRACK_SECOND = 2'd2;

	typedef enum logic [1:0] {OP_INSERT, OP_READ, OP_CLEAR, OP_SHOWER} op_t;
	typedef enum logic {CFG_NUM_BINS, CFG_CROSSING} cfg_idx_t;

	typedef struct packed {
		logic valid;
		logic [1:0] quality;
		logic accel;
		logic pattern;
		logic [KEY_W-1:0] key_wire;
		logic [1:0] shower;
	} slot_t;

	// one memory word: best slot in the low half
	typedef struct packed {
		slot_t s1;
		slot_t s0;
	} pair_t;

	localparam int PAIR_W = $bits(pair_t);

	typedef struct packed {
		logic rd;
		logic wr;
		logic clr;
	} mem_ctl_t;

	typedef struct packed {
		slot_t slot;
		logic [BIN_W-1:0] bin;
		logic [1:0] track;
		logic [XING_W-1:0] crossing;
		logic last;
	} res_t;

	function automatic pair_t pair_insert(pair_t p, slot_t c);
		pair_t r;
		r = p;
		if (!p.s0.valid) begin
			r.s0 = c;
		end else if (c.quality > p.s0.quality) begin
			r.s1 = p.s0;
			r.s0 = c;
		end else if (!p.s1.valid || c.quality > p.s1.quality) begin
			r.s1 = c;
		end
		return r;
	endfunction

endpackage

// ===== design/bttrk_mem.sv =====
module bttrk_mem #(
	parameter int MAX_BINS = bttrk_pkg::MAX_BINS_DEF,
	parameter int AW = 5
) (
	input logic clk,
	input logic arst_n,
	input bttrk_pkg::mem_ctl_t ctl,
	input logic [AW-1:0] addr,
	input bttrk_pkg::pair_t wdata,
	output bttrk_pkg::pair_t rdata
);
	import bttrk_pkg::*;

	logic [PAIR_W-1:0] mem [MAX_BINS];
	logic [PAIR_W-1:0] rd_q;
	logic [MAX_BINS-1:0] vld_q;
	logic rd_vld_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[addr] <= wdata;
		end
		if (ctl.rd) begin
			rd_q <= mem[addr];
		end
	end

	// an entry never written since reset or clear reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (ctl.clr) begin
				vld_q <= '0;
			end else if (ctl.wr) begin
				vld_q[addr] <= 1'b1;
			end
			if (ctl.rd) begin
				rd_vld_q <= vld_q[addr];
			end
		end
	end

	assign rdata = rd_vld_q ? pair_t'(rd_q) : pair_t'('0);

endmodule

// ===== design/bttrk_out.sv =====
module bttrk_out (
	input logic clk,
	input logic arst_n,
	input logic load,
	input bttrk_pkg::res_t word,
	input logic res_stall,
	output logic res_valid,
	output logic free,
	output bttrk_pkg::res_t word_q
);
	import bttrk_pkg::*;

	logic valid_q;

	assign free = !valid_q || !res_stall;
	assign res_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			word_q <= word;
		end
	end

endmodule

// ===== design/best_two_per_bin_tracker.sv =====
// Insert and shower: memory read, then modify and write back (S_MOD).
// Clear: all valid bits of the pair memory drop at once.
// Readout: read the first pair, then one slot at a time, 2 slots per bin; res_stall can hold it.
// The pair memory is single-port with registered read data.
// Asynchronous reset empties the table and loads num_bins 8, crossing_count 0.
module best_two_per_bin_tracker #(
	parameter int MAX_BINS = bttrk_pkg::MAX_BINS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] operation,
	input logic [bttrk_pkg::BIN_W-1:0] bin,
	input logic cand_valid,
	input logic [1:0] cand_quality,
	input logic cand_accel,
	input logic cand_pattern,
	input logic [bttrk_pkg::KEY_W-1:0] cand_key_wire,
	input logic shower_valid,
	input logic [1:0] shower_bits,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [bttrk_pkg::XING_W-1:0] cfg_data,
	output logic res_valid,
	input logic res_stall,
	output logic out_valid,
	output logic [1:0] out_quality,
	output logic out_accel,
	output logic out_pattern,
	output logic [bttrk_pkg::KEY_W-1:0] out_key_wire,
	output logic [1:0] out_shower,
	output logic [bttrk_pkg::BIN_W-1:0] out_bin,
	output logic [1:0] out_track,
	output logic [bttrk_pkg::XING_W-1:0] out_crossing,
	output logic out_last
);
	import bttrk_pkg::*;

	localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BINS);

	typedef enum logic [1:0] {S_IDLE, S_MOD, S_RO0, S_RO1} state_t;

	state_t state_q;
	logic [CNT_W-1:0] num_bins_q;
	logic [XING_W-1:0] xing_q;
	op_t op_q;
	logic [BIN_W-1:0] bin_q;
	slot_t cand_q;
	logic [1:0] shw_q;

	logic [CNT_W-1:0] nb;
	logic accept;
	op_t op_in;
	logic in_range;
	logic [BIN_W-1:0] bin_nxt;
	logic ro_last;
	mem_ctl_t mem_ctl;
	logic [AW-1:0] mem_addr;
	pair_t mem_wdata;
	pair_t rd_pair;
	pair_t shw_pair;
	logic out_load;
	logic out_free;
	res_t out_word;
	res_t res_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_bins_q <= NUM_BINS_RST;
			xing_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_NUM_BINS: num_bins_q <= cfg_data[CNT_W-1:0];
				CFG_CROSSING: xing_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign nb = (num_bins_q > MAX_CNT) ? MAX_CNT : num_bins_q;
	assign accept = in_valid && !in_stall;
	assign op_in = op_t'(operation);
	assign in_range = {1'b0, bin} < nb;
	assign in_stall = (state_q != S_IDLE);
	assign bin_nxt = bin_q + 1'b1;
	assign ro_last = ({1'b0, bin_q} + 1'b1) == nb;

	always_comb begin
		shw_pair = rd_pair;
		shw_pair.s0.shower = shw_q;
		shw_pair.s1.shower = shw_q;
	end

	always_comb begin
		mem_ctl = '0;
		mem_addr = bin[AW-1:0];
		mem_wdata = rd_pair;
		out_load = 1'b0;
		out_word.slot = rd_pair.s0;
		out_word.bin = bin_q;
		out_word.track = TRACK_BEST;
		out_word.crossing = xing_q;
		out_word.last = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (op_in)
						OP_INSERT, OP_SHOWER: mem_ctl.rd = in_range;
						OP_READ: begin
							mem_ctl.rd = (nb != '0);
							mem_addr = '0;
						end
						OP_CLEAR: mem_ctl.clr = 1'b1;
						default: ;
					endcase
				end
			end
			S_MOD: begin
				mem_ctl.wr = 1'b1;
				mem_addr = bin_q[AW-1:0];
				mem_wdata = (op_q == OP_SHOWER) ? shw_pair : pair_insert(rd_pair, cand_q);
			end
			S_RO0: begin
				out_load = out_free;
			end
			S_RO1: begin
				out_load = out_free;
				out_word.slot = rd_pair.s1;
				out_word.track = TRACK_SECOND;
				out_word.last = ro_last;
				// fetch the next pair while the second slot leaves
				if (out_free && !ro_last) begin
					mem_ctl.rd = 1'b1;
					mem_addr = bin_nxt[AW-1:0];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (op_in)
							OP_INSERT, OP_SHOWER: if (in_range) state_q <= S_MOD;
							OP_READ: if (nb != '0) state_q <= S_RO0;
							default: ;
						endcase
					end
				end
				S_MOD: state_q <= S_IDLE;
				S_RO0: if (out_free) state_q <= S_RO1;
				S_RO1: if (out_free) state_q <= ro_last ? S_IDLE : S_RO0;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= op_in;
			bin_q <= (op_in == OP_READ) ? '0 : bin;
			cand_q.valid <= cand_valid;
			cand_q.quality <= cand_quality;
			cand_q.accel <= cand_accel;
			cand_q.pattern <= cand_pattern;
			cand_q.key_wire <= cand_key_wire;
			cand_q.shower <= 2'b00;
			shw_q <= shower_valid ? shower_bits : 2'b00;
		end else if (state_q == S_RO1 && out_free) begin
			bin_q <= bin_nxt;
		end
	end

	bttrk_mem #(
		.MAX_BINS(MAX_BINS),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(mem_ctl),
		.addr(mem_addr),
		.wdata(mem_wdata),
		.rdata(rd_pair)
	);

	bttrk_out u_out (
		.clk(clk),
		.arst_n(arst_n),
		.load(out_load),
		.word(out_word),
		.res_stall(res_stall),
		.res_valid(res_valid),
		.free(out_free),
		.word_q(res_q)
	);

	assign out_valid = res_q.slot.valid;
	assign out_quality = res_q.slot.quality;
	assign out_accel = res_q.slot.accel;
	assign out_pattern = res_q.slot.pattern;
	assign out_key_wire = res_q.slot.key_wire;
	assign out_shower = res_q.slot.shower;
	assign out_bin = res_q.bin;
	assign out_track = res_q.track;
	assign out_crossing = res_q.crossing;
	assign out_last = res_q.last;

`ifndef SYNTHESIS
	a_rmw_writes_back: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (op_in == OP_INSERT || op_in == OP_SHOWER) && in_range |=> mem_ctl.wr)
		else $error("read-modify-write did not write back");

	a_mem_single_access: assert property (@(posedge clk) disable iff (!arst_n)
		mem_ctl.wr |-> !mem_ctl.rd && !mem_ctl.clr)
		else $error("memory write overlaps another access");

	a_empty_readout: assert property (@(posedge clk) disable iff (!arst_n)
		accept && op_in == OP_READ && nb == '0 |=> !in_stall && !mem_ctl.rd)
		else $error("readout with no bins did not return to idle");

	a_cleared_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		mem_ctl.clr ##1 mem_ctl.rd |=> rd_pair == pair_t'('0))
		else $error("pair read after clear is not empty");
`endif

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
	import bttrk_pkg::*;

	localparam int TRK_BINS = MAX_BINS_DEF;
	localparam int DRAIN_CYCLES = 6;
	localparam int REPORT_MAX = 10;

	localparam slot_t NO_SLOT = '0;
	localparam slot_t TOP_SLOT = '{1'b1, 2'd3, 1'b1, 1'b1, 7'd127, 2'd0};

	typedef struct packed {
		logic [1:0] op;
		logic [BIN_W-1:0] bin;
		slot_t cand;
		logic sh_valid;
		logic [1:0] sh_bits;
	} word_t;

	typedef struct packed {
		logic [1:0] op;
		logic [BIN_W-1:0] bin;
		logic cv;
		logic [1:0] cq;
		logic ca;
		logic cp;
		logic [KEY_W-1:0] key;
		logic sv;
		logic [1:0] sb;
		logic peek;
		slot_t best;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [1:0] operation;
	logic [BIN_W-1:0] bin;
	logic cand_valid;
	logic [1:0] cand_quality;
	logic cand_accel;
	logic cand_pattern;
	logic [KEY_W-1:0] cand_key_wire;
	logic shower_valid;
	logic [1:0] shower_bits;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_index;
	logic [XING_W-1:0] cfg_data;
	logic res_valid;
	logic res_stall = 1'b0;
	logic out_valid;
	logic [1:0] out_quality;
	logic out_accel;
	logic out_pattern;
	logic [KEY_W-1:0] out_key_wire;
	logic [1:0] out_shower;
	logic [BIN_W-1:0] out_bin;
	logic [1:0] out_track;
	logic [XING_W-1:0] out_crossing;
	logic out_last;

	// tracker image kept by the bench
	slot_t trk_tab [TRK_BINS][2];
	logic [CNT_W-1:0] nb_reg;
	logic [XING_W-1:0] xing_reg;
	res_t readout_q [$];
	int mismatches = 0;
	bit idle_on = 1'b1;
	int stall_left = 0;

	// directed words; peek rows pin the best slot of the row's bin in that readout
	plan_row_t plan [24] = '{
		'{OP_READ, 5'd0, 1'b0, 2'd0, 1'b0, 1'b0, 7'd0, 1'b0, 2'd0, 1'b1, NO_SLOT},
		'{OP_INSERT, 5'd0, 1'b1, 2'd1, 1'b0, 1'b0, 7'd0, 1'b0, 2'd0, 1'b0, NO_SLOT},
		'{OP_INSERT, 5'd0, 1'b1, 2'd3, 1'b1, 1'b1, 7'd127, 1'b0, 2'd0, 1'b0, NO_SLOT},
		'{OP_INSERT, 5'd0, 1'b1, 2'd2, 1'b0, 1'b1, 7'd5, 1'b0, 2'd0, 1'b0, NO_SLOT},
		'{OP_INSERT, 5'd0, 1'b1, 2'd2, 1'b1, 1'b0, 7'd6, 1'b0, 2'd0, 1'b0, NO_SLOT},
		'{OP_INSERT, 5'd0, 1'b1, 2'd0, 1'b0, 1'b0, 7'd1, 1'b0, 2'd0, 1'b0, NO_SLOT},
		'{OP_SHOWER, 5'd1, 1'b0, 2'd0, 1'b0, 1'b0, 7'd0, 1'b1, 2'd2, 1'b0, NO_SLOT},
		'{OP_INSERT, 5'd1, 1'b1, 2'd0, 1'b0, 1'b0, 7'd64, 1'b0, 2'd0, 1'b0, NO_SLOT},
		'{OP_SHOWER, 5'd1, 1'b0, 2'd0, 1'b0, 1'b0, 7'd0, 1'b1, 2'd3, 1'b0, NO_SLOT},
		'{OP_INSERT, 5'd1, 1'b1, 2'd2, 1'b0, 1'b1, 7'd10, 1'b0, 2'd0, 1'b0, NO_SLOT},
		'{OP_INSERT, 5'd7, 1'b0, 2'd3, 1'b1, 1'b1, 7'd33, 1'b0, 2'd0, 1'b0, NO_SLOT},
		'{OP_INSERT, 5'd7, 1'b1, 2'd1, 1'b0, 1'b0, 7'd34, 1'b0, 2'd0, 1'b0, NO_SLOT},
		'{OP_INSERT, 5'd8, 1'b1, 2'd3, 1'b1, 1'b1, 7'd99, 1'b0, 2'd0, 1'b0, NO_SLOT},
		'{OP_SHOWER, 5'd8, 1'b0, 2'd0, 1'b0, 1'b0, 7'd0, 1'b1, 2'd3, 1'b0, NO_SLOT},
		'{OP_SHOWER, 5'd31, 1'b0, 2'd0, 1'b0, 1'b0, 7'd0, 1'b1, 2'd1, 1'b0, NO_SLOT},
		'{OP_SHOWER, 5'd0, 1'b0, 2'd0, 1'b0, 1'b0, 7'd0, 1'b0, 2'd3, 1'b0, NO_SLOT},
		'{OP_READ, 5'd0, 1'b0, 2'd0, 1'b0, 1'b0, 7'd0, 1'b0, 2'd0, 1'b1, TOP_SLOT},
		'{OP_INSERT, 5'd0, 1'b1, 2'd3, 1'b0, 1'b0, 7'd2, 1'b0, 2'd0, 1'b0, NO_SLOT},
		'{OP_SHOWER, 5'd0, 1'b0, 2'd0, 1'b0, 1'b0, 7'd0, 1'b1, 2'd1, 1'b0, NO_SLOT},
		'{OP_READ, 5'd0, 1'b0, 2'd0, 1'b0, 1'b0, 7'd0, 1'b0, 2'd0, 1'b0, NO_SLOT},
		'{OP_CLEAR, 5'd0, 1'b0, 2'd0, 1'b0, 1'b0, 7'd0, 1'b0, 2'd0, 1'b0, NO_SLOT},
		'{OP_READ, 5'd1, 1'b0, 2'd0, 1'b0, 1'b0, 7'd0, 1'b0, 2'd0, 1'b1, NO_SLOT},
		'{OP_INSERT, 5'd3, 1'b1, 2'd3, 1'b1, 1'b1, 7'd127, 1'b0, 2'd0, 1'b0, NO_SLOT},
		'{OP_READ, 5'd3, 1'b0, 2'd0, 1'b0, 1'b0, 7'd0, 1'b0, 2'd0, 1'b1, TOP_SLOT}
	};

	best_two_per_bin_tracker dut (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int unsigned bins_open();
		return (nb_reg > TRK_BINS) ? TRK_BINS : nb_reg;
	endfunction

	// advance the tracker image by one word; readout queues every open slot
	function automatic void update_tracks(input word_t w);
		slot_t c;
		res_t r;
		int unsigned nb;
		nb = bins_open();
		case (w.op)
		OP_INSERT: begin
			if (w.bin < nb) begin
				c = w.cand;
				c.shower = 2'd0;
				if (!trk_tab[w.bin][0].valid) begin
					trk_tab[w.bin][0] = c;
				end else if (c.quality > trk_tab[w.bin][0].quality) begin
					trk_tab[w.bin][1] = trk_tab[w.bin][0];
					trk_tab[w.bin][0] = c;
				end else if (!trk_tab[w.bin][1].valid ||
						c.quality > trk_tab[w.bin][1].quality) begin
					trk_tab[w.bin][1] = c;
				end
			end
		end
		OP_CLEAR: begin
			foreach (trk_tab[b, t]) trk_tab[b][t] = '0;
		end
		OP_SHOWER: begin
			if (w.bin < nb) begin
				trk_tab[w.bin][0].shower = w.sh_valid ? w.sh_bits : 2'd0;
				trk_tab[w.bin][1].shower = w.sh_valid ? w.sh_bits : 2'd0;
			end
		end
		default: begin
			for (int k = 0; k < 2 * nb; k++) begin
				r.slot = trk_tab[k / 2][k % 2];
				r.bin = BIN_W'(k / 2);
				r.track = (k % 2) ? TRACK_SECOND : TRACK_BEST;
				r.crossing = xing_reg;
				r.last = (k + 1 == 2 * nb);
				readout_q = {readout_q, r};
			end
		end
		endcase
	endfunction

	function automatic word_t random_word();
		word_t w;
		int unsigned pick;
		int unsigned nb;
		nb = bins_open();
		pick = $urandom_range(0, 99);
		w.op = (pick < 58) ? OP_INSERT : (pick < 76) ? OP_SHOWER :
			(pick < 95) ? OP_READ : OP_CLEAR;
		if (nb != 0 && $urandom_range(0, 6) != 0)
			w.bin = BIN_W'($urandom_range(0, nb - 1));
		else
			w.bin = BIN_W'($urandom_range(0, TRK_BINS - 1));
		w.cand.valid = ($urandom_range(0, 9) != 0);
		w.cand.quality = 2'($urandom_range(0, 3));
		w.cand.accel = 1'($urandom_range(0, 1));
		w.cand.pattern = 1'($urandom_range(0, 1));
		w.cand.key_wire = KEY_W'($urandom_range(0, 127));
		w.cand.shower = 2'd0;
		w.sh_valid = ($urandom_range(0, 3) != 0);
		w.sh_bits = 2'($urandom_range(0, 3));
		return w;
	endfunction

	task automatic send_word(input word_t w);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= w.op;
		bin <= w.bin;
		cand_valid <= w.cand.valid;
		cand_quality <= w.cand.quality;
		cand_accel <= w.cand.accel;
		cand_pattern <= w.cand.pattern;
		cand_key_wire <= w.cand.key_wire;
		shower_valid <= w.sh_valid;
		shower_bits <= w.sh_bits;
		do @(posedge clk); while (in_stall);
		update_tracks(w);
	endtask

	// drop valid, wait out pending slots and any insert still in flight
	task automatic settle();
		in_valid <= 1'b0;
		while (readout_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(input logic [XING_W-1:0] nb_data,
			input logic [XING_W-1:0] xing);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= CFG_NUM_BINS;
		cfg_data <= nb_data;
		do @(posedge clk); while (!cfg_ready);
		nb_reg = nb_data[CNT_W-1:0];
		cfg_index <= CFG_CROSSING;
		cfg_data <= xing;
		do @(posedge clk); while (!cfg_ready);
		xing_reg = xing;
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			res_stall <= 1'b1;
		end else if (arst_n && idle_on && $urandom_range(0, 11) == 0) begin
			stall_left <= $urandom_range(0, 14);
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (readout_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected slot word: bin %0d track %0d", out_bin, out_track);
			end else begin
				want = readout_q.pop_front();
				if (out_valid !== want.slot.valid || out_quality !== want.slot.quality ||
						out_accel !== want.slot.accel || out_pattern !== want.slot.pattern ||
						out_key_wire !== want.slot.key_wire ||
						out_shower !== want.slot.shower || out_bin !== want.bin ||
						out_track !== want.track || out_crossing !== want.crossing ||
						out_last !== want.last) begin
					mismatches++;
					if (mismatches <= REPORT_MAX) begin
						$display("slot mismatch exp: v%0d q%0d a%0d p%0d k%0d s%0d b%0d t%0d x%0d l%0d",
							want.slot.valid, want.slot.quality, want.slot.accel,
							want.slot.pattern, want.slot.key_wire, want.slot.shower,
							want.bin, want.track, want.crossing, want.last);
						$display("              got: v%0d q%0d a%0d p%0d k%0d s%0d b%0d t%0d x%0d l%0d",
							out_valid, out_quality, out_accel, out_pattern, out_key_wire,
							out_shower, out_bin, out_track, out_crossing, out_last);
					end
				end
			end
		end
	end

	initial begin
		word_t w;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_INSERT;
		bin = '0;
		cand_valid = 1'b0;
		cand_quality = 2'd0;
		cand_accel = 1'b0;
		cand_pattern = 1'b0;
		cand_key_wire = '0;
		shower_valid = 1'b0;
		shower_bits = 2'd0;
		cfg_valid = 1'b0;
		cfg_index = CFG_NUM_BINS;
		cfg_data = '0;
		nb_reg = NUM_BINS_RST;
		xing_reg = '0;
		foreach (trk_tab[b, t]) trk_tab[b][t] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			w = '{plan[i].op, plan[i].bin,
				'{plan[i].cv, plan[i].cq, plan[i].ca, plan[i].cp, plan[i].key, 2'd0},
				plan[i].sv, plan[i].sb};
			send_word(w);
			// pin the typed best slot into the readout just queued
			if (plan[i].peek && plan[i].bin < bins_open())
				readout_q[readout_q.size() - 2 * bins_open() + 2 * plan[i].bin].slot =
					plan[i].best;
		end

		for (int ph = 0; ph < 9; ph++) begin
			case (ph)
			0: program_regs(12'd32, 12'd4095);
			1: program_regs(12'd1, 12'd0);
			2: program_regs(12'd0, 12'd2730);
			3: program_regs(12'd63, 12'd1365);
			8: program_regs(12'd32, 12'($urandom));
			default: program_regs({6'($urandom), 6'($urandom_range(1, 63))}, 12'($urandom));
			endcase
			idle_on = (ph != 3 && ph != 8);
			repeat ((ph == 2) ? 15 : 42) send_word(random_word());
		end

		settle();
		repeat (16) @(posedge clk);
		if (mismatches == 0 && readout_q.size() == 0)
			$display("best_two_per_bin_tracker test passed");
		else
			$display("best_two_per_bin_tracker test failed");
		$finish;
	end

	initial begin
		#3000000;
		$display("best_two_per_bin_tracker test failed");
		$finish;
	end

endmodule
